[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vph_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vph_pkg
// Types and fixed constants of the VU meter peak hold and decay block.
// ----------------------------------------------------------------------------
package vph_pkg;

    localparam int CHANNELS   = 2;
    localparam int LEVEL_BITS = 6;
    localparam int HOLD_BITS  = 8;
    localparam int STEP_BITS  = 12;
    localparam int INDEX_BITS = 2;

    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [HOLD_BITS-1:0]  t_hold;
    typedef logic [STEP_BITS-1:0]  t_step;

    // Configuration register indexes
    typedef enum logic [INDEX_BITS-1:0] {
        CFG_PEAK_HOLD  = 2'd0,
        CFG_DECAY_HOLD = 2'd1,
        CFG_DECAY_STEP = 2'd2
    } t_cfg_index;

    // Register values after reset
    localparam t_hold PEAK_HOLD_RST  = 8'd30;
    localparam t_hold DECAY_HOLD_RST = 8'd3;
    localparam t_step DECAY_STEP_RST = 12'd273;

    // Ballistics settings shared by all channels
    typedef struct packed {
        t_hold peak_hold;
        t_hold decay_hold;
        t_step decay_step;
    } t_cfg;

endpackage

[rtl/vph_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vph interfaces
// Level input channel, meter result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface vph_lvl_if;
    logic              valid;
    logic              ready;
    vph_pkg::t_level   level_ch0;
    vph_pkg::t_level   level_ch1;

    modport source (output valid, output level_ch0, output level_ch1, input ready);
    modport sink   (input valid, input level_ch0, input level_ch1, output ready);
endinterface

interface vph_mtr_if;
    logic              valid;
    logic              ready;
    vph_pkg::t_level   decay_level_ch0;
    vph_pkg::t_level   peak_level_ch0;
    vph_pkg::t_level   decay_level_ch1;
    vph_pkg::t_level   peak_level_ch1;

    modport source (output valid, output decay_level_ch0, output peak_level_ch0,
                    output decay_level_ch1, output peak_level_ch1, input ready);
    modport sink   (input valid, input decay_level_ch0, input peak_level_ch0,
                    input decay_level_ch1, input peak_level_ch1, output ready);
endinterface

interface vph_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vph_pkg::INDEX_BITS-1:0]      index;
    logic [vph_pkg::STEP_BITS-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/vph_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vph_cfg_regs
// Configuration register file: peak hold, decay hold and decay step.
// ----------------------------------------------------------------------------
module vph_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vph_cfg_if.sink         i_cfg,
    output vph_pkg::t_cfg   o_cfg
);

    vph_pkg::t_cfg r_cfg;

    // Always take writes; an unknown index is dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_hold  <= vph_pkg::PEAK_HOLD_RST;
            r_cfg.decay_hold <= vph_pkg::DECAY_HOLD_RST;
            r_cfg.decay_step <= vph_pkg::DECAY_STEP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                vph_pkg::CFG_PEAK_HOLD: begin
                    r_cfg.peak_hold <= i_cfg.data[vph_pkg::HOLD_BITS-1:0];
                end
                vph_pkg::CFG_DECAY_HOLD: begin
                    r_cfg.decay_hold <= i_cfg.data[vph_pkg::HOLD_BITS-1:0];
                end
                vph_pkg::CFG_DECAY_STEP: begin
                    r_cfg.decay_step <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/vph_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vph_chan
// One channel of meter ballistics: peak hold, decay hold and linear fall,
// with the rounded decay level and the peak held in result registers.
// ----------------------------------------------------------------------------
module vph_chan #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vph_pkg::t_level   i_level,
    input  vph_pkg::t_cfg     i_cfg,
    output vph_pkg::t_level   o_decay_level,
    output vph_pkg::t_level   o_peak_level
);

    localparam int LB = vph_pkg::LEVEL_BITS;
    localparam int DW = LB + FRACTION_BITS;
    localparam int CW = (DW > vph_pkg::STEP_BITS) ? DW : vph_pkg::STEP_BITS;
    localparam logic [DW:0] HALF = (DW+1)'(1) << (FRACTION_BITS - 1);

    vph_pkg::t_level  r_peak;
    vph_pkg::t_hold   r_peak_tmr;
    logic [DW-1:0]    r_decay;
    vph_pkg::t_hold   r_decay_tmr;
    vph_pkg::t_level  r_decay_out;

    vph_pkg::t_level  n_peak;
    vph_pkg::t_hold   n_peak_tmr;
    logic [DW-1:0]    n_decay;
    vph_pkg::t_hold   n_decay_tmr;
    vph_pkg::t_level  n_decay_out;

    vph_pkg::t_level  pk_load;
    vph_pkg::t_hold   pk_tmr;
    logic [DW-1:0]    scaled;
    logic [CW-1:0]    decay_ext;
    logic [CW-1:0]    step_ext;
    logic [CW-1:0]    decay_diff;
    logic [DW:0]      rnd_sum;
    logic [LB:0]      rnd_level;

    // Peak: follow a level at or above it, count the hold down, then drop to zero
    always_comb begin
        if (i_level >= r_peak) begin
            pk_load = i_level;
            pk_tmr  = i_cfg.peak_hold;
        end else begin
            pk_load = r_peak;
            pk_tmr  = r_peak_tmr;
        end
        if (pk_tmr == '0) begin
            n_peak     = '0;
            n_peak_tmr = pk_tmr;
        end else begin
            n_peak     = pk_load;
            n_peak_tmr = pk_tmr - 1'b1;
        end
    end

    // Decay: jump up, hold, then fall by the step and saturate at zero
    assign scaled     = {i_level, {FRACTION_BITS{1'b0}}};
    assign decay_ext  = CW'(r_decay);
    assign step_ext   = CW'(i_cfg.decay_step);
    assign decay_diff = decay_ext - step_ext;

    always_comb begin
        n_decay     = r_decay;
        n_decay_tmr = r_decay_tmr;
        if (scaled >= r_decay) begin
            n_decay     = scaled;
            n_decay_tmr = i_cfg.decay_hold;
        end else if (r_decay_tmr == '0) begin
            n_decay = (decay_ext > step_ext) ? decay_diff[DW-1:0] : '0;
        end else begin
            n_decay_tmr = r_decay_tmr - 1'b1;
        end
    end

    // Round the new decay level to nearest, half up, clamp to full scale
    assign rnd_sum   = {1'b0, n_decay} + HALF;
    assign rnd_level = rnd_sum[DW:FRACTION_BITS];
    assign n_decay_out = rnd_level[LB] ? {LB{1'b1}} : rnd_level[LB-1:0];

    // Advance the channel state once per accepted frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_peak_tmr  <= '0;
            r_decay     <= '0;
            r_decay_tmr <= '0;
        end else if (i_en) begin
            r_peak      <= n_peak;
            r_peak_tmr  <= n_peak_tmr;
            r_decay     <= n_decay;
            r_decay_tmr <= n_decay_tmr;
        end
    end

    // Result register for the rounded level
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_decay_out <= n_decay_out;
        end
    end

    assign o_decay_level = r_decay_out;
    assign o_peak_level  = r_peak;

endmodule

[rtl/vu_peak_hold_decay.sv]
`timescale 1ns / 1ps
// Takes one level word per display frame and returns one meter word per frame.
// A word may be accepted in every clock cycle while the result side takes each
// result. Each word passes the input register and then the result register.
// While the word sits in the input register, every channel reads its peak and
// decay state. When the update stage advances, each channel rewrites that state
// and loads the result register. Back-pressure on the result side stalls the
// update stage. While a result waits, the input register takes a word only if
// it is empty, and then holds that word until the result slot drains. Settings
// should be written only while no frame is in flight.
// ----------------------------------------------------------------------------
// vu_peak_hold_decay
// VU meter ballistics with peak hold and hold-then-fall decay per channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vu_peak_hold_decay #(
    parameter int FRACTION_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vph_lvl_if.sink   i_lvl,
    vph_mtr_if.source o_mtr,
    vph_cfg_if.sink   i_cfg
);

    vph_pkg::t_cfg    cfg;
    logic             r_in_vld;
    vph_pkg::t_level  r_lvl [vph_pkg::CHANNELS];
    logic             r_out_vld;
    logic             advance;
    vph_pkg::t_level  decay_lvl [vph_pkg::CHANNELS];
    vph_pkg::t_level  peak_lvl  [vph_pkg::CHANNELS];

    vph_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Update stage moves when the input register holds a word and the result slot is empty or being drained
    assign advance     = r_in_vld && (!r_out_vld || o_mtr.ready);
    assign i_lvl.ready = !r_in_vld || advance;

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_lvl.ready) begin
            r_in_vld <= i_lvl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lvl.valid && i_lvl.ready) begin
            r_lvl[0] <= i_lvl.level_ch0;
            r_lvl[1] <= i_lvl.level_ch1;
        end
    end

    // Result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_mtr.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    for (genvar c = 0; c < vph_pkg::CHANNELS; c++) begin : g_chan
        vph_chan #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_chan (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (advance),
            .i_level       (r_lvl[c]),
            .i_cfg         (cfg),
            .o_decay_level (decay_lvl[c]),
            .o_peak_level  (peak_lvl[c])
        );
    end

    assign o_mtr.valid           = r_out_vld;
    assign o_mtr.decay_level_ch0 = decay_lvl[0];
    assign o_mtr.peak_level_ch0  = peak_lvl[0];
    assign o_mtr.decay_level_ch1 = decay_lvl[1];
    assign o_mtr.peak_level_ch1  = peak_lvl[1];

    // A frame that leaves the input register shows up as a result next cycle
    `ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, advance, o_mtr.valid, "update lost a result")
    // A stalled result must freeze the channel state
    `ASSERT_SAME(a_stall_blocks_update, i_clk, i_rst_n, o_mtr.valid && !o_mtr.ready, !advance, "state moved under a stalled result")
    // An accepted word is held in the input register
    `ASSERT_NEXT(a_accept_fills_input, i_clk, i_rst_n, i_lvl.valid && i_lvl.ready, r_in_vld, "accepted word dropped")

endmodule
